### rtl/c8is_pkg.sv
`default_nettype none
package c8is_pkg;
    localparam int MEMORY_BYTES_DEF = 4096;
    localparam int STACK_DEPTH_DEF  = 16;
    localparam logic [11:0] PC_RESET = 12'h200;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_UNSUP     = 2'd1;
    localparam logic [1:0] ST_OVERFLOW  = 2'd2;
    localparam logic [1:0] ST_UNDERFLOW = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE, S_FETCH_HI, S_FETCH_LO, S_DECODE, S_EXEC, S_STORE, S_LOAD_REQ, S_LOAD_WAIT,
        S_BCD, S_RESULT
    } ctrl_state_t;

    // controller to datapath
    typedef struct packed {
        logic take_item;    // latch input transaction
        logic write_byte;   // memory write from item
        logic fetch_hi;     // read pc
        logic fetch_lo;     // read pc+1, capture hi byte
        logic decode;       // capture lo byte
        logic exec;         // execute the decoded instruction
        logic store_step;   // Fx55 one register
        logic load_req;     // Fx65 read I+k
        logic load_step;    // Fx65 write Vk
        logic bcd_step;     // Fx33 one digit
        logic result_load;  // load output register
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_write;
        logic is_store;
        logic is_load;
        logic is_bcd;
        logic last_k;       // k == x (or third BCD digit)
    } dp_stat_t;
endpackage
`default_nettype wire

### rtl/c8is_ctrl.sv
`default_nettype none
module c8is_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               in_valid,
    output logic                    in_ready,
    output logic                    out_valid,
    input  wire logic               out_ready,
    input  wire c8is_pkg::dp_stat_t stat,
    output c8is_pkg::dp_cmd_t       cmd
);
    c8is_pkg::ctrl_state_t state_reg, state_next;
    logic out_valid_reg, out_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= c8is_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == c8is_pkg::S_IDLE);
    assign out_valid = out_valid_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            c8is_pkg::S_IDLE:      if (in_valid) state_next = c8is_pkg::S_FETCH_HI;
            c8is_pkg::S_FETCH_HI: begin
                if (stat.is_write) state_next = c8is_pkg::S_RESULT;
                else               state_next = c8is_pkg::S_FETCH_LO;
            end
            c8is_pkg::S_FETCH_LO:  state_next = c8is_pkg::S_DECODE;
            c8is_pkg::S_DECODE:    state_next = c8is_pkg::S_EXEC;
            c8is_pkg::S_EXEC: begin
                if (stat.is_store)     state_next = c8is_pkg::S_STORE;
                else if (stat.is_load) state_next = c8is_pkg::S_LOAD_REQ;
                else if (stat.is_bcd)  state_next = c8is_pkg::S_BCD;
                else                   state_next = c8is_pkg::S_RESULT;
            end
            c8is_pkg::S_STORE:     if (stat.last_k) state_next = c8is_pkg::S_RESULT;
            c8is_pkg::S_LOAD_REQ:  state_next = c8is_pkg::S_LOAD_WAIT;
            c8is_pkg::S_LOAD_WAIT: begin
                if (stat.last_k) state_next = c8is_pkg::S_RESULT;
                else             state_next = c8is_pkg::S_LOAD_REQ;
            end
            c8is_pkg::S_BCD:       if (stat.last_k) state_next = c8is_pkg::S_RESULT;
            c8is_pkg::S_RESULT:    if (!out_valid_reg || out_ready) state_next = c8is_pkg::S_IDLE;
            default:               state_next = c8is_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        cmd = '0;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            c8is_pkg::S_IDLE:      cmd.take_item = in_valid;
            c8is_pkg::S_FETCH_HI: begin
                cmd.write_byte = stat.is_write;
                cmd.fetch_hi   = !stat.is_write;
            end
            c8is_pkg::S_FETCH_LO:  cmd.fetch_lo = 1'b1;
            c8is_pkg::S_DECODE:    cmd.decode = 1'b1;
            c8is_pkg::S_EXEC:      cmd.exec = 1'b1;
            c8is_pkg::S_STORE:     cmd.store_step = 1'b1;
            c8is_pkg::S_LOAD_REQ:  cmd.load_req = 1'b1;
            c8is_pkg::S_LOAD_WAIT: cmd.load_step = 1'b1;
            c8is_pkg::S_BCD:       cmd.bcd_step = 1'b1;
            c8is_pkg::S_RESULT: begin
                if (!out_valid_reg || out_ready) begin
                    cmd.result_load = 1'b1;
                    out_valid_next  = 1'b1;
                end
            end
            default: cmd = '0;
        endcase
    end

    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        in_ready |-> !(cmd.exec || cmd.store_step || cmd.load_step))
        else $error("ready while busy");
    a_take_fetch: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.take_item |=> state_reg == c8is_pkg::S_FETCH_HI)
        else $error("item not fetched");
    a_result_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.result_load |=> out_valid_reg)
        else $error("result lost");
endmodule
`default_nettype wire

### rtl/c8is_datapath.sv
`default_nettype none
module c8is_datapath #(
    parameter int MEMORY_BYTES = c8is_pkg::MEMORY_BYTES_DEF,
    parameter int STACK_DEPTH  = c8is_pkg::STACK_DEPTH_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire c8is_pkg::dp_cmd_t cmd,
    output c8is_pkg::dp_stat_t     stat,
    input  wire logic [62:0]       in_data,
    output logic [82:0]            out_data
);
    localparam int AW  = $clog2(MEMORY_BYTES);
    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam int SIW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    logic [7:0]  mem [MEMORY_BYTES];
    logic [11:0] stack_mem [STACK_DEPTH];

    logic [62:0] item_reg;
    logic [11:0] pc_reg, idx_reg;
    logic [7:0]  v_reg [16];
    logic [SPW-1:0] sp_reg;
    logic [7:0]  hi_reg, rd_reg;
    logic [15:0] word_reg;
    logic [11:0] ret_reg;
    logic [3:0]  k_reg;
    logic [82:0] res_reg, res_next;
    logic [11:0] npc_reg;

    logic        op_w;
    logic [11:0] i_addr;
    logic [7:0]  i_data, i_rand, i_delay;
    logic [15:0] i_keys;
    logic [3:0]  i_wkey;
    logic        i_coll;
    assign op_w    = item_reg[0];
    assign i_addr  = item_reg[12:1];
    assign i_data  = item_reg[20:13];
    assign i_keys  = item_reg[36:21];
    assign i_wkey  = item_reg[40:37];
    assign i_rand  = item_reg[48:41];
    assign i_delay = item_reg[56:49];
    assign i_coll  = item_reg[57];

    logic [3:0] hi_n, x, y, n;
    logic [7:0] kk, vx, vy;
    logic [11:0] nnn;
    assign hi_n = word_reg[15:12];
    assign x    = word_reg[11:8];
    assign y    = word_reg[7:4];
    assign n    = word_reg[3:0];
    assign kk   = word_reg[7:0];
    assign nnn  = word_reg[11:0];
    assign vx   = v_reg[x];
    assign vy   = v_reg[y];

    assign stat.is_write = op_w;
    assign stat.is_store = (hi_n == 4'hF) && (kk == 8'h55);
    assign stat.is_load  = (hi_n == 4'hF) && (kk == 8'h65);
    assign stat.is_bcd   = (hi_n == 4'hF) && (kk == 8'h33);
    assign stat.last_k   = stat.is_bcd ? (k_reg == 4'd2) : (k_reg == x);

    // memory port: one write, one registered read per cycle
    logic          mwe;
    logic [11:0]   maddr;
    logic [7:0]    mwd;
    logic [7:0]    bcd_digit;
    // BCD digits by reciprocal multiplication, exact over 0..255
    logic [13:0]   bcd_hp;
    logic [1:0]    bcd_h;
    logic [7:0]    bcd_rem;
    logic [14:0]   bcd_tp;
    logic [3:0]    bcd_t;
    logic [7:0]    bcd_o;
    always_comb begin
        bcd_hp  = {6'd0, vx} * 14'd41;
        bcd_h   = bcd_hp[13:12];
        bcd_rem = vx - {6'd0, bcd_h} * 8'd100;
        bcd_tp  = {7'd0, bcd_rem} * 15'd205;
        bcd_t   = bcd_tp[14:11];
        bcd_o   = bcd_rem - {4'd0, bcd_t} * 8'd10;
        case (k_reg[1:0])
            2'd0:    bcd_digit = {6'd0, bcd_h};
            2'd1:    bcd_digit = {4'd0, bcd_t};
            default: bcd_digit = bcd_o;
        endcase
    end
    always_comb begin
        mwe = 1'b0; maddr = pc_reg; mwd = v_reg[k_reg];
        if (cmd.write_byte) begin
            mwe = 1'b1; maddr = i_addr; mwd = i_data;
        end else if (cmd.fetch_lo) begin
            maddr = pc_reg + 12'd1;
        end else if (cmd.store_step) begin
            mwe = 1'b1; maddr = idx_reg + 12'(k_reg);
        end else if (cmd.load_req) begin
            maddr = idx_reg + 12'(k_reg);
        end else if (cmd.bcd_step) begin
            mwe = 1'b1; maddr = idx_reg + 12'(k_reg); mwd = bcd_digit;
        end
    end
    always_ff @(posedge aclk) begin
        if (mwe) mem[maddr[AW-1:0]] <= mwd;
        rd_reg <= mem[maddr[AW-1:0]];
    end

    // return stack: read top in decode, write on call
    logic push;
    assign push = cmd.exec && hi_n == 4'h2 && sp_reg < SPW'(STACK_DEPTH);
    logic [SIW-1:0] pop_idx;
    assign pop_idx = SIW'(sp_reg - SPW'(1));
    always_ff @(posedge aclk) begin
        if (push) stack_mem[sp_reg[SIW-1:0]] <= pc_reg;
        if (cmd.decode) ret_reg <= stack_mem[pop_idx];
    end

    // execute
    logic [1:0]  st;
    logic [11:0] npc;
    logic        we_x, we_f, we_i;
    logic [7:0]  rx, rf;
    logic [11:0] ri;
    logic [8:0]  sum;
    logic        key_t;
    always_comb begin
        st = c8is_pkg::ST_OK; npc = pc_reg + 12'd2;
        we_x = 1'b0; we_f = 1'b0; we_i = 1'b0;
        rx = 8'd0; rf = 8'd0; ri = 12'd0;
        sum = {1'b0, vx} + {1'b0, vy};
        key_t = i_keys[vx[3:0]] && (vx < 8'd16);
        res_next = '0;
        case (hi_n)
            4'h0: begin
                if (word_reg == 16'h00E0) res_next[14] = 1'b1;
                else if (word_reg == 16'h00EE) begin
                    if (sp_reg == '0) st = c8is_pkg::ST_UNDERFLOW;
                    else npc = ret_reg + 12'd2;
                end
            end
            4'h1: npc = nnn;
            4'h2: begin
                if (sp_reg >= SPW'(STACK_DEPTH)) st = c8is_pkg::ST_OVERFLOW;
                else npc = nnn;
            end
            4'h3: if (vx == kk) npc = pc_reg + 12'd4;
            4'h4: if (vx != kk) npc = pc_reg + 12'd4;
            4'h5: begin
                if (n != 4'd0) st = c8is_pkg::ST_UNSUP;
                else if (vx == vy) npc = pc_reg + 12'd4;
            end
            4'h6: begin we_x = 1'b1; rx = kk; end
            4'h7: begin we_x = 1'b1; rx = vx + kk; end
            4'h8: begin
                we_x = 1'b1;
                case (n)
                    4'h0: rx = vy;
                    4'h1: rx = vx | vy;
                    4'h2: rx = vx & vy;
                    4'h3: rx = vx ^ vy;
                    4'h4: begin rx = sum[7:0]; we_f = 1'b1; rf = {7'd0, sum[8]}; end
                    4'h5: begin rx = vx - vy; we_f = 1'b1; rf = {7'd0, vx > vy}; end
                    4'h6: begin rx = {1'b0, vx[7:1]}; we_f = 1'b1; rf = {7'd0, vx[0]}; end
                    4'h7: begin rx = vy - vx; we_f = 1'b1; rf = {7'd0, vy > vx}; end
                    4'hE: begin rx = {vx[6:0], 1'b0}; we_f = 1'b1; rf = {7'd0, vx[7]}; end
                    default: begin we_x = 1'b0; st = c8is_pkg::ST_UNSUP; end
                endcase
            end
            4'h9: begin
                if (n != 4'd0) st = c8is_pkg::ST_UNSUP;
                else if (vx != vy) npc = pc_reg + 12'd4;
            end
            4'hA: begin we_i = 1'b1; ri = nnn; end
            4'hB: npc = nnn + 12'(v_reg[0]);
            4'hC: begin we_x = 1'b1; rx = i_rand & kk; end
            4'hD: begin
                res_next[15] = 1'b1;
                res_next[23:16] = vx;
                res_next[31:24] = vy;
                res_next[35:32] = n;
                res_next[47:36] = idx_reg;
                we_f = 1'b1; rf = {7'd0, i_coll};
            end
            4'hE: begin
                if (kk == 8'h9E) begin
                    if (key_t) npc = pc_reg + 12'd4;
                end else if (kk == 8'hA1) begin
                    if (!key_t) npc = pc_reg + 12'd4;
                end else st = c8is_pkg::ST_UNSUP;
            end
            default: begin
                case (kk)
                    8'h07: begin we_x = 1'b1; rx = i_delay; end
                    8'h0A: begin we_x = 1'b1; rx = {4'd0, i_wkey}; end
                    8'h15: begin res_next[48] = 1'b1; res_next[57:50] = vx; end
                    8'h18: begin res_next[49] = 1'b1; res_next[57:50] = vx; end
                    8'h1E: begin we_i = 1'b1; ri = idx_reg + 12'(vx); end
                    8'h29: begin we_i = 1'b1; ri = 12'(vx[3:0]) * 12'd5; end
                    8'h33, 8'h55, 8'h65: ;
                    default: st = c8is_pkg::ST_UNSUP;
                endcase
            end
        endcase
        if (st != c8is_pkg::ST_OK) begin
            res_next = '0; npc = pc_reg;
            we_x = 1'b0; we_f = 1'b0; we_i = 1'b0;
        end
        res_next[11:0]  = npc;
        res_next[13:12] = st;
        res_next[82:58] = '0;
    end

    always_ff @(posedge aclk) begin
        if (cmd.take_item) item_reg <= in_data;
        if (cmd.fetch_lo)  hi_reg <= rd_reg;
        if (cmd.decode)    word_reg <= {hi_reg, rd_reg};
        if (cmd.take_item) word_reg <= 16'd0;
        if (cmd.exec) begin
            res_reg <= res_next;
            npc_reg <= npc;
        end
        if (cmd.write_byte) begin
            res_reg <= {71'd0, pc_reg};
            npc_reg <= pc_reg;
        end
        if (cmd.result_load) out_data <= {word_reg, res_reg[57:0], 9'd0} >> 9;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg  <= c8is_pkg::PC_RESET;
            idx_reg <= '0;
            sp_reg  <= '0;
            k_reg   <= '0;
            for (int i = 0; i < 16; i++) v_reg[i] <= 8'd0;
        end else begin
            if (cmd.exec) begin
                k_reg <= '0;
                // VF written as flag wins over VF as destination
                if (we_x && !(we_f && x == 4'hF)) v_reg[x] <= rx;
                if (we_f) v_reg[15] <= rf;
                if (we_i) idx_reg <= ri;
                if (push) sp_reg <= sp_reg + SPW'(1);
                if (hi_n == 4'h0 && word_reg == 16'h00EE && sp_reg != '0)
                    sp_reg <= sp_reg - SPW'(1);
            end
            if (cmd.store_step || cmd.bcd_step || cmd.load_step) k_reg <= k_reg + 4'd1;
            if (cmd.load_step) v_reg[k_reg] <= rd_reg;
            if (cmd.result_load) pc_reg <= npc_reg;
        end
    end

    a_sp_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        sp_reg <= SPW'(STACK_DEPTH)) else $error("stack pointer out of range");
    a_push_grow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |=> sp_reg == $past(sp_reg) + SPW'(1)) else $error("push lost");
    a_store_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.store_step |-> stat.is_store) else $error("store step outside Fx55");
endmodule
`default_nettype wire

### rtl/chip8_instruction_step.sv
`default_nettype none
// Channel  Direction  Contents
// s_axis   in         one item: memory byte write or one instruction step (tuser = op)
// m_axis   out        one result per item
//
// A write item passes through fetch and result; a step through fetch, decode,
// execute and result, with loops over V0..Vx for Fx55 and Fx65 and over three
// digits for Fx33: the single memory port serialises fetch and register copies.
// aresetn is synchronous and active low: PC to 0x200, I, V and SP to zero.
// The result waits in an output register; a stalled m_axis holds it. The next
// item is still taken, but its result is loaded only once the old one has moved on.
module chip8_instruction_step #(
    parameter int MEMORY_BYTES = c8is_pkg::MEMORY_BYTES_DEF,
    parameter int STACK_DEPTH  = c8is_pkg::STACK_DEPTH_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // address, data, key_mask, waited_key, random_byte, delay_value, collision
    input  wire logic [63:0] s_axis_tdata,
    // op
    input  wire logic        s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // next_pc, status, clear_screen, draw_request, draw_x, draw_y, draw_rows,
    // sprite_address, delay_write, sound_write, timer_value, instruction
    output logic [79:0]      m_axis_tdata
);
    c8is_pkg::dp_cmd_t  cmd;
    c8is_pkg::dp_stat_t stat;
    logic [82:0] res;

    c8is_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .stat(stat), .cmd(cmd)
    );

    // datapath item word: op in bit 0, tdata fields above it
    c8is_datapath #(.MEMORY_BYTES(MEMORY_BYTES), .STACK_DEPTH(STACK_DEPTH)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .stat(stat),
        .in_data({s_axis_tdata[61:0], s_axis_tuser}), .out_data(res)
    );

    // result: 58 field bits then the 16-bit instruction word
    assign m_axis_tdata = {6'd0, res[73:0]};
endmodule
`default_nettype wire

### tb/c8is_tb_pkg.sv
package c8is_tb_pkg;
    // item kind, sent on s_axis_tuser (bit 0 of the checker's item word)
    localparam logic OP_STEP  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // whole words
    localparam logic [15:0] W_CLS = 16'h00e0;
    localparam logic [15:0] W_RET = 16'h00ee;

    // instruction groups, top nibble
    localparam logic [3:0] G_SYS  = 4'h0;
    localparam logic [3:0] G_JP   = 4'h1;
    localparam logic [3:0] G_CALL = 4'h2;
    localparam logic [3:0] G_SE   = 4'h3;
    localparam logic [3:0] G_SNE  = 4'h4;
    localparam logic [3:0] G_SEV  = 4'h5;
    localparam logic [3:0] G_LD   = 4'h6;
    localparam logic [3:0] G_ADD  = 4'h7;
    localparam logic [3:0] G_ALU  = 4'h8;
    localparam logic [3:0] G_SNEV = 4'h9;
    localparam logic [3:0] G_LDI  = 4'ha;
    localparam logic [3:0] G_JPV  = 4'hb;
    localparam logic [3:0] G_RND  = 4'hc;
    localparam logic [3:0] G_DRW  = 4'hd;
    localparam logic [3:0] G_SKP  = 4'he;
    localparam logic [3:0] G_MISC = 4'hf;

    // 8xyN sub-operations
    localparam logic [3:0] ALU_MOV  = 4'h0;
    localparam logic [3:0] ALU_OR   = 4'h1;
    localparam logic [3:0] ALU_AND  = 4'h2;
    localparam logic [3:0] ALU_XOR  = 4'h3;
    localparam logic [3:0] ALU_ADD  = 4'h4;
    localparam logic [3:0] ALU_SUB  = 4'h5;
    localparam logic [3:0] ALU_SHR  = 4'h6;
    localparam logic [3:0] ALU_SUBN = 4'h7;
    localparam logic [3:0] ALU_SHL  = 4'he;

    // low bytes of Ex and Fx
    localparam logic [7:0] KK_SKP    = 8'h9e;
    localparam logic [7:0] KK_SKNP   = 8'ha1;
    localparam logic [7:0] KK_GET_DT = 8'h07;
    localparam logic [7:0] KK_KEY    = 8'h0a;
    localparam logic [7:0] KK_SET_DT = 8'h15;
    localparam logic [7:0] KK_SET_ST = 8'h18;
    localparam logic [7:0] KK_ADD_I  = 8'h1e;
    localparam logic [7:0] KK_FONT   = 8'h29;
    localparam logic [7:0] KK_BCD    = 8'h33;
    localparam logic [7:0] KK_STORE  = 8'h55;
    localparam logic [7:0] KK_LOAD   = 8'h65;

    // m_axis_tdata[73:0], last field (next_pc) lowest
    typedef struct packed {
        logic [15:0] instruction;
        logic [7:0]  timer_value;
        logic        sound_write;
        logic        delay_write;
        logic [11:0] sprite_address;
        logic [3:0]  draw_rows;
        logic [7:0]  draw_y;
        logic [7:0]  draw_x;
        logic        draw_request;
        logic        clear_screen;
        logic [1:0]  status;
        logic [11:0] next_pc;
    } step_result_t;
endpackage

### tb/c8is_checker.sv
module c8is_checker #(
    parameter int STACK_DEPTH = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    input  wire logic        s_ready,
    input  wire logic [63:0] s_data,
    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire logic [79:0] m_data,
    output int               fail_count
);
    import c8is_pkg::*;
    import c8is_tb_pkg::*;

    logic [11:0] pc_r;
    logic [11:0] idx_r;
    logic [7:0]  vreg [16];
    logic [11:0] ret_img [STACK_DEPTH];
    int          sp_r;
    logic [7:0]  mem_img [4096];
    logic        mem_set [4096];
    step_result_t expected_results [$];
    int          results_seen;

    initial fail_count = 0;

    task automatic report(input string msg);
        fail_count++;
        if (fail_count <= 40)
            $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    task automatic cmp_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
        if (got !== want)
            report($sformatf("result %0d %s got 0x%0h want 0x%0h",
                             results_seen, name, got, want));
    endtask

    task automatic execute_item(input logic [63:0] d);
        logic [11:0] pc_now, npc, ad;
        logic [15:0] w;
        logic [3:0]  x, y, n;
        logic [7:0]  kk, vx, vy;
        logic [8:0]  sum;
        logic [15:0] keys;
        logic [1:0]  st;
        step_result_t r;
        r = '0;
        pc_now = pc_r;
        st = ST_OK;
        if (d[0] == OP_WRITE) begin
            mem_img[d[12:1]] = d[20:13];
            mem_set[d[12:1]] = 1'b1;
            r.next_pc = pc_now;
        end else begin
            ad = pc_now + 12'd1;
            w = {mem_img[pc_now], mem_img[ad]};
            x = w[11:8]; y = w[7:4]; n = w[3:0]; kk = w[7:0];
            vx = vreg[x]; vy = vreg[y];
            keys = d[36:21];
            npc = pc_now + 12'd2;
            case (w[15:12])
                G_SYS: begin
                    if (w == W_CLS) begin
                        r.clear_screen = 1'b1;
                    end else if (w == W_RET) begin
                        if (sp_r == 0) begin
                            st = ST_UNDERFLOW;
                        end else begin
                            sp_r--;
                            npc = ret_img[sp_r] + 12'd2;
                        end
                    end
                end
                G_JP: npc = w[11:0];
                G_CALL: begin
                    if (sp_r >= STACK_DEPTH) begin
                        st = ST_OVERFLOW;
                    end else begin
                        ret_img[sp_r] = pc_now;
                        sp_r++;
                        npc = w[11:0];
                    end
                end
                G_SE:  if (vx == kk) npc = pc_now + 12'd4;
                G_SNE: if (vx != kk) npc = pc_now + 12'd4;
                G_SEV: begin
                    if (n != 0) st = ST_UNSUP;
                    else if (vx == vy) npc = pc_now + 12'd4;
                end
                G_LD:  vreg[x] = kk;
                G_ADD: vreg[x] = vx + kk;
                G_ALU: begin
                    case (n)
                        ALU_MOV: vreg[x] = vy;
                        ALU_OR:  vreg[x] = vx | vy;
                        ALU_AND: vreg[x] = vx & vy;
                        ALU_XOR: vreg[x] = vx ^ vy;
                        ALU_ADD: begin
                            sum = {1'b0, vx} + {1'b0, vy};
                            vreg[x] = sum[7:0];
                            vreg[15] = {7'd0, sum[8]};
                        end
                        ALU_SUB: begin
                            vreg[x] = vx - vy;
                            vreg[15] = {7'd0, vx > vy};
                        end
                        ALU_SHR: begin
                            vreg[x] = vx >> 1;
                            vreg[15] = {7'd0, vx[0]};
                        end
                        ALU_SUBN: begin
                            vreg[x] = vy - vx;
                            vreg[15] = {7'd0, vy > vx};
                        end
                        ALU_SHL: begin
                            vreg[x] = vx << 1;
                            vreg[15] = {7'd0, vx[7]};
                        end
                        default: st = ST_UNSUP;
                    endcase
                end
                G_SNEV: begin
                    if (n != 0) st = ST_UNSUP;
                    else if (vx != vy) npc = pc_now + 12'd4;
                end
                G_LDI: idx_r = w[11:0];
                G_JPV: npc = w[11:0] + {4'd0, vreg[0]};
                G_RND: vreg[x] = d[48:41] & kk;
                G_DRW: begin
                    r.draw_request = 1'b1;
                    r.draw_x = vx;
                    r.draw_y = vy;
                    r.draw_rows = n;
                    r.sprite_address = idx_r;
                    vreg[15] = {7'd0, d[57]};
                end
                G_SKP: begin
                    // key numbers above fifteen count as not held
                    if (kk == KK_SKP) begin
                        if (vx < 16 && keys[vx[3:0]]) npc = pc_now + 12'd4;
                    end else if (kk == KK_SKNP) begin
                        if (!(vx < 16 && keys[vx[3:0]])) npc = pc_now + 12'd4;
                    end else begin
                        st = ST_UNSUP;
                    end
                end
                default: begin
                    case (kk)
                        KK_GET_DT: vreg[x] = d[56:49];
                        KK_KEY:    vreg[x] = {4'd0, d[40:37]};
                        KK_SET_DT: begin
                            r.delay_write = 1'b1;
                            r.timer_value = vx;
                        end
                        KK_SET_ST: begin
                            r.sound_write = 1'b1;
                            r.timer_value = vx;
                        end
                        KK_ADD_I: idx_r = idx_r + {4'd0, vx};
                        KK_FONT:  idx_r = {8'd0, vx[3:0]} * 12'd5;
                        KK_BCD: begin
                            for (int k = 0; k < 3; k++) begin
                                ad = idx_r + k[11:0];
                                mem_set[ad] = 1'b1;
                                case (k)
                                    0: mem_img[ad] = vx / 8'd100;
                                    1: mem_img[ad] = (vx / 8'd10) % 8'd10;
                                    default: mem_img[ad] = vx % 8'd10;
                                endcase
                            end
                        end
                        KK_STORE: begin
                            for (int k = 0; k <= x; k++) begin
                                ad = idx_r + k[11:0];
                                mem_img[ad] = vreg[k];
                                mem_set[ad] = 1'b1;
                            end
                        end
                        KK_LOAD: begin
                            for (int k = 0; k <= x; k++) begin
                                ad = idx_r + k[11:0];
                                vreg[k] = mem_img[ad];
                            end
                        end
                        default: st = ST_UNSUP;
                    endcase
                end
            endcase
            if (st != ST_OK) begin
                r = '0;
                npc = pc_now;
            end
            pc_r = npc;
            r.next_pc = npc;
            r.status = st;
            r.instruction = w;
        end
        expected_results.push_back(r);
    endtask

    task automatic check_result(input logic [79:0] raw);
        step_result_t got, want;
        got = raw[73:0];
        if (expected_results.size() == 0) begin
            report($sformatf("result with nothing expected: 0x%0h", raw));
        end else begin
            want = expected_results.pop_front();
            cmp_field("next_pc", got.next_pc, want.next_pc);
            cmp_field("status", got.status, want.status);
            cmp_field("clear_screen", got.clear_screen, want.clear_screen);
            cmp_field("draw_request", got.draw_request, want.draw_request);
            cmp_field("draw_x", got.draw_x, want.draw_x);
            cmp_field("draw_y", got.draw_y, want.draw_y);
            cmp_field("draw_rows", got.draw_rows, want.draw_rows);
            cmp_field("sprite_address", got.sprite_address, want.sprite_address);
            cmp_field("delay_write", got.delay_write, want.delay_write);
            cmp_field("sound_write", got.sound_write, want.sound_write);
            cmp_field("timer_value", got.timer_value, want.timer_value);
            cmp_field("instruction", got.instruction, want.instruction);
        end
        results_seen++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            pc_r = PC_RESET;
            idx_r = '0;
            sp_r = 0;
            results_seen = 0;
            for (int i = 0; i < 16; i++) vreg[i] = '0;
            for (int i = 0; i < 4096; i++) begin
                mem_img[i] = '0;
                mem_set[i] = 1'b0;
            end
        end else begin
            // results first: a result leaving now belongs to an older item
            if (m_valid && m_ready) check_result(m_data);
            if (s_valid && s_ready) execute_item(s_data);
        end
    end
endmodule

### tb/tb_chip8_instruction_step.sv
module tb_chip8_instruction_step;
    import c8is_tb_pkg::*;

    // idle cycles with no transaction on either side before giving up
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int RANDOM_ITEMS   = 1250;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // address, data, key_mask, waited_key, random_byte, delay_value, collision
    logic [63:0] s_axis_tdata = '0;
    // op
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // next_pc, status, clear_screen, draw_request, draw_x, draw_y, draw_rows,
    // sprite_address, delay_write, sound_write, timer_value, instruction
    logic [79:0] m_axis_tdata;

    int  fail_count;
    int  items_sent = 0;
    int  steps_sent = 0;
    int  idle_cycles = 0;
    bit  hold_req = 1'b0;   // asks the receiver for one long hold-off
    bit  calm = 1'b0;       // sender adds no random gaps while set

    always #2 aclk = ~aclk;

    chip8_instruction_step dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    // checker sees the item as one word: op in bit 0, tdata fields above
    c8is_checker chk (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_axis_tvalid),
        .s_ready(s_axis_tready),
        .s_data({s_axis_tdata[62:0], s_axis_tuser}),
        .m_valid(m_axis_tvalid),
        .m_ready(m_axis_tready),
        .m_data(m_axis_tdata),
        .fail_count(fail_count)
    );

    // Watchdog: only cycles with no transaction at all are counted.
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (aresetn) begin
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog expired with %0d results outstanding",
                         chk.expected_results.size());
                $display("tb_chip8_instruction_step NOT OK");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // Result side: mostly short stalls, now and then a long one, plus a single
    // very long hold-off on request so the block backs up onto its input.
    initial begin : receiver
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                stall_left = 400;
            end
            if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else begin
                m_axis_tready <= 1'b1;
                if ($urandom_range(0, 99) < 12) stall_left = $urandom_range(1, 3);
                else if ($urandom_range(0, 199) == 0) stall_left = $urandom_range(20, 80);
            end
        end
    end

    // One input transaction. Valid drops after each acceptance and the task waits
    // for the next clock edge, so the checker's copy of the core state is settled
    // before the next item is built from it.
    task automatic send_item(input logic [63:0] d);
        int gap;
        gap = 0;
        if (!calm) begin
            if ($urandom_range(0, 19) == 0) gap = $urandom_range(20, 60);
            else gap = $urandom_range(0, 2);
        end
        repeat (gap) @(posedge aclk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= d[0];
        s_axis_tdata <= {1'b0, d[63:1]};
        do @(posedge aclk); while (!(s_axis_tvalid && s_axis_tready));
        s_axis_tvalid <= 1'b0;
        items_sent++;
        if (d[0] == OP_STEP) steps_sent++;
        @(posedge aclk);
    endtask

    // Unused fields are randomised on every transaction for bit coverage.
    task automatic send_write(input logic [11:0] a, input logic [7:0] v);
        send_item({6'd0, 1'($urandom), 8'($urandom), 8'($urandom), 4'($urandom),
                   16'($urandom), v, a, OP_WRITE});
    endtask

    task automatic send_step();
        send_item({6'd0, 1'($urandom), 8'($urandom), 8'($urandom), 4'($urandom),
                   16'($urandom), 8'($urandom), 12'($urandom), OP_STEP});
    endtask

    function automatic logic [15:0] pick_opcode();
        logic [11:0] nnn;
        logic [3:0]  x, y, n;
        logic [7:0]  kk;
        logic [15:0] w;
        nnn = $urandom; x = $urandom; y = $urandom; n = $urandom; kk = $urandom;
        case ($urandom_range(0, 19))
            0:  w = W_CLS;
            1:  w = W_RET;
            2:  w = {G_JP, nnn};
            3:  w = {G_CALL, nnn};
            4:  w = {G_SE, x, kk};
            5:  w = {G_SNE, x, kk};
            6:  w = {G_SEV, x, y, ($urandom_range(0, 1) ? 4'd0 : n)};
            7:  w = {G_LD, x, kk};
            8:  w = {G_ADD, x, kk};
            9, 10: w = {G_ALU, x, y, n};
            11: w = {G_SNEV, x, y, ($urandom_range(0, 1) ? 4'd0 : n)};
            12: w = {G_LDI, nnn};
            13: w = {G_JPV, nnn};
            14: w = {G_RND, x, kk};
            15: w = {G_DRW, x, y, n};
            16: begin
                case ($urandom_range(0, 2))
                    0: w = {G_SKP, x, KK_SKP};
                    1: w = {G_SKP, x, KK_SKNP};
                    default: w = {G_SKP, x, kk};
                endcase
            end
            17, 18: begin
                case ($urandom_range(0, 10))
                    0: w = {G_MISC, x, KK_GET_DT};
                    1: w = {G_MISC, x, KK_KEY};
                    2: w = {G_MISC, x, KK_SET_DT};
                    3: w = {G_MISC, x, KK_SET_ST};
                    4: w = {G_MISC, x, KK_ADD_I};
                    5: w = {G_MISC, x, KK_FONT};
                    6: w = {G_MISC, x, KK_BCD};
                    7: w = {G_MISC, x, KK_STORE};
                    8, 9: w = {G_MISC, x, KK_LOAD};
                    default: w = {G_MISC, x, kk};
                endcase
            end
            default: w = $urandom;
        endcase
        return w;
    endfunction

    // Runs one instruction at the current program counter. The word there is
    // written first when it was never written, when one is forced, or at
    // random to keep loops from repeating. Fx65 sources never written get
    // random bytes so no unwritten memory is ever read.
    task automatic run_instr(input bit forced, input logic [15:0] word);
        logic [11:0] pc, pc1, ad;
        logic [15:0] w;
        pc = chk.pc_r;
        pc1 = pc + 12'd1;
        w = word;
        if (forced || !chk.mem_set[pc] || !chk.mem_set[pc1] || $urandom_range(0, 1)) begin
            if (!forced) w = pick_opcode();
            send_write(pc, w[15:8]);
            send_write(pc1, w[7:0]);
        end
        w = {chk.mem_img[pc], chk.mem_img[pc1]};
        if (w[15:12] == G_MISC && w[7:0] == KK_LOAD) begin
            for (int k = 0; k <= w[11:8]; k++) begin
                ad = chk.idx_r + k[11:0];
                if (!chk.mem_set[ad]) send_write(ad, 8'($urandom));
            end
        end
        send_step();
    endtask

    initial begin : stimulus
        int calls_left;
        bit held;
        bit drained;
        held = 1'b0;
        drained = 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: return on an empty stack, clear, register extremes, flag
        // register as operand of add and shift, draw, store all sixteen
        // registers, an unsupported skip, and a write at the top byte.
        run_instr(1'b1, W_RET);
        run_instr(1'b1, W_CLS);
        run_instr(1'b1, {G_LD, 4'hf, 8'hff});
        run_instr(1'b1, {G_ALU, 4'hf, 4'hf, ALU_ADD});
        run_instr(1'b1, {G_ALU, 4'hf, 4'hf, ALU_SHL});
        run_instr(1'b1, {G_DRW, 4'hf, 4'hf, 4'hf});
        run_instr(1'b1, {G_MISC, 4'hf, KK_STORE});
        run_instr(1'b1, {G_SEV, 4'h0, 4'h1, 4'h1});
        send_write(12'hfff, 8'hff);

        while (items_sent < RANDOM_ITEMS) begin
            // receiver holds off for long while items keep coming
            if (!held && steps_sent >= 250) begin
                hold_req = 1'b1;
                held = 1'b1;
            end
            // sender waits for the pipe to drain once
            if (!drained && steps_sent >= 450) begin
                drained = 1'b1;
                while (chk.expected_results.size() != 0) @(posedge aclk);
            end
            if ($urandom_range(0, 15) == 0) calm = ~calm;
            case ($urandom_range(0, 39))
                0, 1, 2: send_write(12'($urandom), 8'($urandom));
                3: begin
                    // call chain deep enough to overflow, then unwind past empty
                    calls_left = 18;
                    while (calls_left > 0) begin
                        run_instr(1'b1, {G_CALL, 12'($urandom)});
                        calls_left--;
                    end
                    calls_left = 18;
                    while (calls_left > 0) begin
                        run_instr(1'b1, W_RET);
                        calls_left--;
                    end
                end
                default: run_instr(1'b0, 16'd0);
            endcase
        end

        while (chk.expected_results.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        $display("covered %0d transactions in: %0d instruction steps and %0d byte writes,",
                 items_sent, steps_sent, items_sent - steps_sent);
        $display("with call chains to overflow, long output stalls and a full drain; %0d %s",
                 chk.results_seen, "results compared");
        if (fail_count == 0) begin
            $display("tb_chip8_instruction_step OK");
        end else begin
            $display("tb_chip8_instruction_step NOT OK");
        end
        $finish;
    end
endmodule
